// File: sv/pcs_pkg.sv
package pcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_AMBER   = 3'd1,
    PH_RED     = 3'd2,
    PH_WALK    = 3'd3,
    PH_FON     = 3'd4,
    PH_FOFF    = 3'd5,
    PH_RESTORE = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    REG_AMBER      = 3'd0,
    REG_RED_CLEAR  = 3'd1,
    REG_WALK       = 3'd2,
    REG_FLASH_HALF = 3'd3,
    REG_FLASH_CYC  = 3'd4,
    REG_RESTORE    = 3'd5
  } reg_index_t;

  localparam int unsigned TickW  = 16;
  localparam int unsigned FlashW = 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [TickW-1:0]  AmberReset     = 16'd2000;
  localparam logic [TickW-1:0]  RedClearReset  = 16'd2000;
  localparam logic [TickW-1:0]  WalkReset      = 16'd10000;
  localparam logic [TickW-1:0]  FlashHalfReset = 16'd500;
  localparam logic [FlashW-1:0] FlashCycReset  = 4'd8;
  localparam logic [TickW-1:0]  RestoreReset   = 16'd500;

  typedef struct packed {
    logic [TickW-1:0]  amber_ticks;
    logic [TickW-1:0]  red_clear_ticks;
    logic [TickW-1:0]  walk_ticks;
    logic [TickW-1:0]  flash_half_ticks;
    logic [FlashW-1:0] flash_cycles;
    logic [TickW-1:0]  restore_ticks;
  } cfg_t;

endpackage

// File: sv/pcs_if.sv
interface pcs_in_if (input logic clk);
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

interface pcs_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       lamp_red;
  logic       lamp_amber;
  logic       lamp_green;
  logic       lamp_stop_man;
  logic       lamp_walk_man;
  logic [2:0] phase;

  modport source (
    output valid, output lamp_red, output lamp_amber, output lamp_green,
    output lamp_stop_man, output lamp_walk_man, output phase, input ready
  );
  modport sink (
    input valid, input lamp_red, input lamp_amber, input lamp_green,
    input lamp_stop_man, input lamp_walk_man, input phase, output ready
  );
endinterface

// File: sv/pcs_regs.sv
module pcs_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcs_pkg::AddrW-1:0] paddr,
  input  logic [pcs_pkg::DataW-1:0] pwdata,
  output logic [pcs_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output pcs_pkg::cfg_t             cfg
);

  pcs_pkg::cfg_t regs;
  logic [2:0]    index;
  logic          wr;

  assign index  = paddr[pcs_pkg::AddrW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.amber_ticks      <= pcs_pkg::AmberReset;
      regs.red_clear_ticks  <= pcs_pkg::RedClearReset;
      regs.walk_ticks       <= pcs_pkg::WalkReset;
      regs.flash_half_ticks <= pcs_pkg::FlashHalfReset;
      regs.flash_cycles     <= pcs_pkg::FlashCycReset;
      regs.restore_ticks    <= pcs_pkg::RestoreReset;
    end else if (wr) begin
      unique case (index)
        pcs_pkg::REG_AMBER:      regs.amber_ticks      <= pwdata[15:0];
        pcs_pkg::REG_RED_CLEAR:  regs.red_clear_ticks  <= pwdata[15:0];
        pcs_pkg::REG_WALK:       regs.walk_ticks       <= pwdata[15:0];
        pcs_pkg::REG_FLASH_HALF: regs.flash_half_ticks <= pwdata[15:0];
        pcs_pkg::REG_FLASH_CYC:  regs.flash_cycles     <= pwdata[3:0];
        pcs_pkg::REG_RESTORE:    regs.restore_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      pcs_pkg::REG_AMBER:      prdata = 32'(regs.amber_ticks);
      pcs_pkg::REG_RED_CLEAR:  prdata = 32'(regs.red_clear_ticks);
      pcs_pkg::REG_WALK:       prdata = 32'(regs.walk_ticks);
      pcs_pkg::REG_FLASH_HALF: prdata = 32'(regs.flash_half_ticks);
      pcs_pkg::REG_FLASH_CYC:  prdata = 32'(regs.flash_cycles);
      pcs_pkg::REG_RESTORE:    prdata = 32'(regs.restore_ticks);
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: sv/pcs_core.sv
module pcs_core (
  input  logic          clk,
  input  logic          rst,
  input  pcs_pkg::cfg_t cfg,
  pcs_in_if.sink        in_ch,
  pcs_out_if.source     out_ch
);

  pcs_pkg::phase_t                  phase, phase_next, ph_cur;
  logic [pcs_pkg::TickW-1:0]        tick_count, tick_next;
  logic [pcs_pkg::FlashW-1:0]       flash_count, flash_next;
  logic [pcs_pkg::TickW-1:0]        tick_base, tick_inc, len;
  logic [pcs_pkg::FlashW-1:0]       flash_inc;
  logic                             phase_done;
  logic                             accept;
  logic                             out_valid;
  logic                             r, a, g, sm, wm;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  // press on an idle tick makes that tick the first amber tick
  always_comb begin
    ph_cur    = phase;
    tick_base = tick_count;
    if (phase == pcs_pkg::PH_IDLE && !in_ch.button_level) begin
      ph_cur    = pcs_pkg::PH_AMBER;
      tick_base = '0;
    end
  end

  always_comb begin
    unique case (ph_cur)
      pcs_pkg::PH_AMBER:                   len = cfg.amber_ticks;
      pcs_pkg::PH_RED:                     len = cfg.red_clear_ticks;
      pcs_pkg::PH_WALK:                    len = cfg.walk_ticks;
      pcs_pkg::PH_FON, pcs_pkg::PH_FOFF:   len = cfg.flash_half_ticks;
      default:                             len = cfg.restore_ticks;
    endcase
  end

  assign tick_inc   = tick_base + 16'd1;
  assign flash_inc  = flash_count + 4'd1;
  // counter wrap to zero also ends the phase
  assign phase_done = (ph_cur != pcs_pkg::PH_IDLE) &&
                      (tick_inc >= len || tick_inc == '0);

  // next state
  always_comb begin
    phase_next = ph_cur;
    flash_next = flash_count;
    tick_next  = (ph_cur == pcs_pkg::PH_IDLE) ? tick_count : tick_inc;
    if (phase_done) begin
      tick_next = '0;
      unique case (ph_cur)
        pcs_pkg::PH_AMBER: phase_next = pcs_pkg::PH_RED;
        pcs_pkg::PH_RED:   phase_next = pcs_pkg::PH_WALK;
        pcs_pkg::PH_WALK: begin
          phase_next = pcs_pkg::PH_FON;
          flash_next = '0;
        end
        pcs_pkg::PH_FON:   phase_next = pcs_pkg::PH_FOFF;
        pcs_pkg::PH_FOFF: begin
          if (flash_inc >= cfg.flash_cycles || flash_inc == '0) begin
            phase_next = pcs_pkg::PH_RESTORE;
            flash_next = '0;
          end else begin
            phase_next = pcs_pkg::PH_FON;
            flash_next = flash_inc;
          end
        end
        default:           phase_next = pcs_pkg::PH_IDLE;
      endcase
    end
  end

  // lamp outputs
  always_comb begin
    r  = 1'b0;
    a  = 1'b0;
    g  = 1'b0;
    sm = 1'b0;
    wm = 1'b0;
    unique case (ph_cur)
      pcs_pkg::PH_IDLE: begin
        g  = 1'b1;
        sm = 1'b1;
      end
      pcs_pkg::PH_AMBER: begin
        a  = 1'b1;
        sm = 1'b1;
      end
      pcs_pkg::PH_RED: begin
        r  = 1'b1;
        sm = 1'b1;
      end
      pcs_pkg::PH_WALK: begin
        r  = 1'b1;
        wm = 1'b1;
      end
      pcs_pkg::PH_FON: begin
        a  = 1'b1;
        wm = 1'b1;
      end
      pcs_pkg::PH_FOFF: ;
      default: begin
        a  = 1'b1;
        sm = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= pcs_pkg::PH_IDLE;
      tick_count  <= '0;
      flash_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        tick_count  <= tick_next;
        flash_count <= flash_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.lamp_red      <= r;
      out_ch.lamp_amber    <= a;
      out_ch.lamp_green    <= g;
      out_ch.lamp_stop_man <= sm;
      out_ch.lamp_walk_man <= wm;
      out_ch.phase         <= 3'(ph_cur);
    end
  end

endmodule

// File: sv/pedestrian_crossing_sequencer_top.sv
// result: registered on acceptance, so the result item is valid in the cycle after its tick item is accepted
// throughput: one tick item per cycle while the output is not stalled, set by the single phase/counter update
// input is ready while the result register is empty or being taken, so an output stall holds it
// reset (rst, synchronous, active high) returns to idle with counters cleared
// and loads the default timing registers
module pedestrian_crossing_sequencer_top (
  input  logic                      clk,
  input  logic                      rst,
  pcs_in_if.sink                    in_ch,
  pcs_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcs_pkg::AddrW-1:0] paddr,
  input  logic [pcs_pkg::DataW-1:0] pwdata,
  output logic [pcs_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  pcs_pkg::cfg_t cfg;

  pcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

  a_green_idle: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.lamp_green) |-> out_ch.phase == pcs_pkg::PH_IDLE)
    else $error("traffic green outside idle");

  a_men_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.lamp_walk_man && out_ch.lamp_stop_man))
    else $error("both pedestrian lamps lit");

  a_green_walk: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.lamp_green && out_ch.lamp_walk_man))
    else $error("traffic green with walk man");

endmodule
